@@ sv/ihb_pkg.sv @@
package ihb_pkg;

  localparam int SIDE_DEF  = 48;
  localparam int IDX_W     = 6;
  localparam int FRAC_W    = 16;
  localparam int CMD_W     = 2;
  localparam int CNT_W     = 3;
  localparam int CFG_IDX_W = 2;

  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [FRAC_W-1:0]    frac_t;
  typedef logic [FRAC_W:0]      prob_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  localparam cmd_t CMD_UPDATE = 2'd0;
  localparam cmd_t CMD_READ   = 2'd1;
  localparam cmd_t CMD_WRITE  = 2'd2;

  localparam cfg_idx_t CFG_THR_TWO  = 2'd0;
  localparam cfg_idx_t CFG_THR_FOUR = 2'd1;

  localparam frac_t THR_RESET = 16'h8000;
  localparam prob_t PROB_ONE  = 17'h10000;
  localparam prob_t PROB_HALF = 17'h08000;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_N0,
    ST_RD_N1,
    ST_RD_N2,
    ST_RD_N3,
    ST_RD_CTR,
    ST_FINISH
  } ihb_state_t;

  // probability of up for a given number of up neighbours
  function automatic prob_t up_threshold(input cnt_t count, input frac_t thr_two,
                                         input frac_t thr_four);
    prob_t p;
    case (count)
      3'd0:    p = PROB_ONE - {1'b0, thr_four};
      3'd1:    p = PROB_ONE - {1'b0, thr_two};
      3'd3:    p = {1'b0, thr_two};
      3'd4:    p = {1'b0, thr_four};
      default: p = PROB_HALF;
    endcase
    return p;
  endfunction

endpackage

@@ sv/ising_heat_bath_site_update.sv @@
// Heat-bath site update on a SIDE x SIDE torus of one-bit spins.
// Input channel (in_valid / in_stall): one request names a site by row and
// column with a command: update, read or write. Every request gives exactly
// one result on the output channel (out_valid / out_stall).
// Configuration (cfg_valid / cfg_ready, always ready): index 0 writes
// threshold_two, index 1 threshold_four; other indexes are ignored. Write only
// while the block is idle.
// Storage: the spins sit in a single-port bit memory with registered read. An
// update reads four neighbours and the site, then writes back. A read reads
// the site, a write reads it and writes it back, and an out-of-range site or
// an unused command touches no memory. No new request is taken until the
// current one has left its finish step.
// Reset: the grid is swept to all down, one site a cycle over all SIDE*SIDE
// sites (2304 at the default), with in_stall high; thresholds return to one half.
// A result waits in the output register while out_stall is high; the next
// request is taken meanwhile and holds before its write back until the
// register is free.
module ising_heat_bath_site_update #(
  parameter int SIDE = ihb_pkg::SIDE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ihb_pkg::cmd_t                 in_command,
  input  logic [ihb_pkg::IDX_W-1:0]     in_row,
  input  logic [ihb_pkg::IDX_W-1:0]     in_col,
  input  ihb_pkg::frac_t                in_uniform,
  input  logic                          in_write_spin,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_spin,
  output ihb_pkg::cnt_t                 out_up_neighbours,
  output logic                          out_changed,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  ihb_pkg::cfg_idx_t             cfg_index,
  input  ihb_pkg::frac_t                cfg_data
);

  import ihb_pkg::*;

  localparam int DEPTH  = SIDE * SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROW_W  = $clog2(SIDE);
  localparam int CMP_W  = ($clog2(SIDE + 1) > IDX_W) ? $clog2(SIDE + 1) : IDX_W;

  ihb_state_t        state_r, state_nxt;
  cmd_t              cmd_r;
  logic [ROW_W-1:0]  row_r, col_r;
  frac_t             uni_r;
  logic              wsp_r;
  logic              ok_r;
  cnt_t              cnt_r, cnt_nxt;
  logic              acc_r;
  logic [ADDR_W-1:0] clr_r;
  frac_t             thr2_r, thr4_r;
  logic              out_valid_r;
  logic              out_spin_r;
  cnt_t              out_cnt_r;
  logic              out_chg_r;

  logic              accept;
  logic              site_ok;
  logic              fin_go;
  logic              fin_load;
  logic              clr_done;
  logic [ROW_W-1:0]  row_up, row_dn, col_up, col_dn;
  logic [ROW_W-1:0]  sel_row, sel_col;
  logic              ram_we, ram_re, ram_wdata, ram_rdata;
  logic [ADDR_W-1:0] ram_addr;
  logic              old_spin, new_spin, new_chg, do_store;
  cnt_t              new_cnt;

  assign accept  = in_valid && !in_stall;
  assign site_ok = (CMP_W'(in_row) < CMP_W'(SIDE)) && (CMP_W'(in_col) < CMP_W'(SIDE)) &&
                   (in_command == CMD_UPDATE || in_command == CMD_READ ||
                    in_command == CMD_WRITE);
  assign fin_go   = !out_valid_r || !out_stall;
  assign fin_load = (state_r == ST_FINISH) && fin_go;
  assign clr_done = (clr_r == ADDR_W'(DEPTH - 1));

  // wrap-around neighbour coordinates
  assign row_up = (row_r == ROW_W'(SIDE - 1)) ? '0 : row_r + 1'b1;
  assign row_dn = (row_r == '0) ? ROW_W'(SIDE - 1) : row_r - 1'b1;
  assign col_up = (col_r == ROW_W'(SIDE - 1)) ? '0 : col_r + 1'b1;
  assign col_dn = (col_r == '0) ? ROW_W'(SIDE - 1) : col_r - 1'b1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (!site_ok) state_nxt = ST_FINISH;
          else if (in_command == CMD_UPDATE) state_nxt = ST_RD_N0;
          else state_nxt = ST_RD_CTR;
        end
      end
      ST_RD_N0:  state_nxt = ST_RD_N1;
      ST_RD_N1:  state_nxt = ST_RD_N2;
      ST_RD_N2:  state_nxt = ST_RD_N3;
      ST_RD_N3:  state_nxt = ST_RD_CTR;
      ST_RD_CTR: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (fin_go) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    ram_re   = 1'b0;
    ram_we   = 1'b0;
    sel_row  = row_r;
    sel_col  = col_r;
    case (state_r)
      ST_CLEAR:  ram_we = 1'b1;
      ST_IDLE:   in_stall = 1'b0;
      ST_RD_N0: begin
        ram_re  = 1'b1;
        sel_row = row_up;
      end
      ST_RD_N1: begin
        ram_re  = 1'b1;
        sel_row = row_dn;
      end
      ST_RD_N2: begin
        ram_re  = 1'b1;
        sel_col = col_up;
      end
      ST_RD_N3: begin
        ram_re  = 1'b1;
        sel_col = col_dn;
      end
      ST_RD_CTR: ram_re = 1'b1;
      ST_FINISH: ram_we = fin_go && do_store;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign ram_addr = (state_r == ST_CLEAR) ? clr_r :
                    ADDR_W'(ADDR_W'(sel_row) * ADDR_W'(SIDE)) + ADDR_W'(sel_col);
  assign ram_wdata = (state_r == ST_CLEAR) ? 1'b0 : new_spin;

  // result of the command, formed while the site's own bit is on the read port
  always_comb begin
    old_spin = ram_rdata && ok_r;
    new_spin = 1'b0;
    new_chg  = 1'b0;
    new_cnt  = '0;
    do_store = 1'b0;
    if (ok_r) begin
      case (cmd_r)
        CMD_UPDATE: begin
          new_spin = {1'b0, uni_r} < up_threshold(cnt_r, thr2_r, thr4_r);
          new_chg  = new_spin ^ old_spin;
          new_cnt  = cnt_r;
          do_store = 1'b1;
        end
        CMD_READ: new_spin = old_spin;
        CMD_WRITE: begin
          new_spin = wsp_r;
          new_chg  = wsp_r ^ old_spin;
          do_store = 1'b1;
        end
        default: new_spin = 1'b0;
      endcase
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) cnt_nxt = '0;
    else if (acc_r) cnt_nxt = cnt_r + CNT_W'(ram_rdata);
  end

  ihb_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      acc_r       <= 1'b0;
      cnt_r       <= '0;
      thr2_r      <= THR_RESET;
      thr4_r      <= THR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= (state_r == ST_RD_N0) || (state_r == ST_RD_N1) ||
                 (state_r == ST_RD_N2) || (state_r == ST_RD_N3);
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_THR_TWO:  thr2_r <= cfg_data;
          CFG_THR_FOUR: thr4_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (fin_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      row_r <= ROW_W'(in_row);
      col_r <= ROW_W'(in_col);
      uni_r <= in_uniform;
      wsp_r <= in_write_spin;
      ok_r  <= site_ok;
    end
    if (fin_load) begin
      out_spin_r <= new_spin;
      out_cnt_r  <= new_cnt;
      out_chg_r  <= new_chg;
    end
  end

  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_spin          = out_spin_r;
  assign out_up_neighbours = out_cnt_r;
  assign out_changed       = out_chg_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    fin_load |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while stalled");

  a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("grid memory read and written in one cycle");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |-> (cnt_r <= CNT_W'(4)))
    else $error("neighbour count out of range");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |=> !out_valid_r)
    else $error("result during clearing pass");

endmodule

@@ sv/ihb_ram.sv @@
module ihb_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ dv/ising_heat_bath_site_update_tb.sv @@
module ising_heat_bath_site_update_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ihb_pkg::*;

  localparam int SIDE = SIDE_DEF;
  localparam cmd_t CMD_NONE = 2'd3;
  localparam int QUIET_LIMIT = 8000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic spin;
    cnt_t up_neighbours;
    logic changed;
  } site_result_t;

  class site_update_board;
    bit spins[SIDE*SIDE];
    frac_t thr_two;
    frac_t thr_four;
    site_result_t expected_results[$];
    int unsigned mismatches;

    function new();
      foreach (spins[i]) spins[i] = 1'b0;
      thr_two = THR_RESET;
      thr_four = THR_RESET;
      mismatches = 0;
    endfunction

    function void set_threshold(cfg_idx_t idx, frac_t data);
      case (idx)
        CFG_THR_TWO:  thr_two = data;
        CFG_THR_FOUR: thr_four = data;
        default: ;
      endcase
    endfunction

    // chance of up in 1/65536 units, complement taken at 17 bits
    function prob_t up_limit(int count);
      case (count)
        0: return PROB_ONE - {1'b0, thr_four};
        1: return PROB_ONE - {1'b0, thr_two};
        3: return {1'b0, thr_two};
        4: return {1'b0, thr_four};
        default: return PROB_HALF;
      endcase
    endfunction

    function void note_request(cmd_t cmd, int unsigned row, int unsigned col, frac_t uni,
                               logic ws);
      site_result_t res;
      int unsigned addr;
      int count;
      res = '0;
      if (row < SIDE && col < SIDE) begin
        addr = row * SIDE + col;
        case (cmd)
          CMD_UPDATE: begin
            count = spins[((row + 1) % SIDE) * SIDE + col]
                  + spins[((row + SIDE - 1) % SIDE) * SIDE + col]
                  + spins[row * SIDE + (col + 1) % SIDE]
                  + spins[row * SIDE + (col + SIDE - 1) % SIDE];
            res.up_neighbours = cnt_t'(count);
            res.spin = ({1'b0, uni} < up_limit(count));
            res.changed = res.spin ^ spins[addr];
            spins[addr] = res.spin;
          end
          CMD_READ: res.spin = spins[addr];
          CMD_WRITE: begin
            res.spin = ws;
            res.changed = ws ^ spins[addr];
            spins[addr] = ws;
          end
          default: ;
        endcase
      end
      expected_results.push_back(res);
    endfunction

    function void check_result(logic spin, cnt_t up_neighbours, logic changed);
      site_result_t exp_res;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing pending: spin %0d up_neighbours %0d changed %0d",
                 $time, spin, up_neighbours, changed);
        mismatches++;
        return;
      end
      exp_res = expected_results.pop_front();
      if (spin !== exp_res.spin) begin
        $display("%0t: spin expected %0d actual %0d", $time, exp_res.spin, spin);
        mismatches++;
      end
      if (up_neighbours !== exp_res.up_neighbours) begin
        $display("%0t: up_neighbours expected %0d actual %0d", $time,
                 exp_res.up_neighbours, up_neighbours);
        mismatches++;
      end
      if (changed !== exp_res.changed) begin
        $display("%0t: changed expected %0d actual %0d", $time, exp_res.changed, changed);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  cmd_t                 in_command;
  logic [IDX_W-1:0]     in_row;
  logic [IDX_W-1:0]     in_col;
  frac_t                in_uniform;
  logic                 in_write_spin;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_spin;
  cnt_t                 out_up_neighbours;
  logic                 out_changed;
  logic                 cfg_valid;
  logic                 cfg_ready;
  cfg_idx_t             cfg_index;
  frac_t                cfg_data;

  site_update_board board;
  bit calm;
  int quiet_cycles;

  ising_heat_bath_site_update i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_row            (in_row),
    .in_col            (in_col),
    .in_uniform        (in_uniform),
    .in_write_spin     (in_write_spin),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_spin          (out_spin),
    .out_up_neighbours (out_up_neighbours),
    .out_changed       (out_changed),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 15);
    end
  end

  // sample all handshakes on the edge, before any driver update lands
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        board.note_request(in_command, in_row, in_col, in_uniform, in_write_spin);
      if (out_valid && !out_stall)
        board.check_result(out_spin, out_up_neighbours, out_changed);
      if (cfg_valid && cfg_ready)
        board.set_threshold(cfg_index, cfg_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("ising_heat_bath_site_update verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_request(input cmd_t cmd, input int unsigned row, input int unsigned col,
                              input frac_t uni, input logic ws);
    int gap;
    gap = 0;
    if (!calm)
      while ($urandom_range(0, 99) < 15) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_row <= IDX_W'(row);
    in_col <= IDX_W'(col);
    in_uniform <= uni;
    in_write_spin <= ws;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid and hold until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic set_thresholds(input frac_t two, input frac_t four);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_THR_TWO;
    cfg_data <= two;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_THR_FOUR;
    cfg_data <= four;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic int unsigned corner_coord();
    return (SIDE - 2 + $urandom_range(0, 4)) % SIDE;
  endfunction

  task automatic run_random(input int count);
    int unsigned roll, row, col;
    cmd_t cmd;
    frac_t uni;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      // most traffic stays near the corner so neighbours are often up
      if ($urandom_range(0, 99) < 75) begin
        row = corner_coord();
        col = corner_coord();
      end else begin
        row = $urandom_range(0, SIDE - 1);
        col = $urandom_range(0, SIDE - 1);
      end
      if (roll < 55) begin
        cmd = CMD_UPDATE;
      end else if (roll < 72) begin
        cmd = CMD_WRITE;
      end else if (roll < 88) begin
        cmd = CMD_READ;
      end else if (roll < 93) begin
        cmd = CMD_NONE;
      end else begin
        cmd = cmd_t'($urandom_range(0, 2));
        if ($urandom_range(0, 1)) row = $urandom_range(SIDE, 63);
        else col = $urandom_range(SIDE, 63);
      end
      case ($urandom_range(0, 19))
        0: uni = '0;
        1: uni = '1;
        2: uni = PROB_HALF[FRAC_W-1:0];
        3: uni = PROB_HALF[FRAC_W-1:0] - 1'b1;
        default: uni = frac_t'($urandom_range(0, 65535));
      endcase
      send_request(cmd, row, col, uni, logic'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    board = new();
    calm = 1'b0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_UPDATE;
    in_row = '0;
    in_col = '0;
    in_uniform = '0;
    in_write_spin = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_THR_TWO;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset thresholds, wrap-around neighbours at the corner
    send_request(CMD_READ,   0,  0,  16'h0000, 1'b1);
    send_request(CMD_UPDATE, 0,  0,  16'h0000, 1'b0);
    send_request(CMD_WRITE,  47, 0,  16'hFFFF, 1'b1);
    send_request(CMD_WRITE,  0,  47, 16'h0000, 1'b1);
    send_request(CMD_WRITE,  1,  0,  16'h0000, 1'b1);
    send_request(CMD_UPDATE, 0,  0,  16'hFFFF, 1'b1);
    send_request(CMD_WRITE,  0,  1,  16'h0000, 1'b1);
    send_request(CMD_UPDATE, 0,  0,  16'h7FFF, 1'b0);
    send_request(CMD_READ,   47, 47, 16'hFFFF, 1'b0);
    send_request(CMD_WRITE,  47, 47, 16'h0000, 1'b0);
    send_request(CMD_UPDATE, 47, 47, 16'h8000, 1'b1);
    // out-of-range sites and the unused command
    send_request(CMD_READ,   48, 0,  16'h0000, 1'b0);
    send_request(CMD_WRITE,  63, 63, 16'hFFFF, 1'b1);
    send_request(CMD_NONE,   0,  0,  16'h0000, 1'b1);
    send_request(CMD_UPDATE, 0,  48, 16'h0000, 1'b0);
    send_request(CMD_UPDATE, 24, 24, 16'h0000, 1'b0);
    drain();

    // zero thresholds: low counts always go up, high counts never
    set_thresholds(16'h0000, 16'h0000);
    send_request(CMD_UPDATE, 20, 20, 16'hFFFF, 1'b0);
    send_request(CMD_WRITE,  21, 20, 16'h0000, 1'b1);
    send_request(CMD_UPDATE, 20, 20, 16'hFFFF, 1'b0);
    send_request(CMD_WRITE,  20, 21, 16'h0000, 1'b1);
    send_request(CMD_WRITE,  19, 20, 16'h0000, 1'b1);
    send_request(CMD_UPDATE, 20, 20, 16'h0000, 1'b1);
    drain();

    set_thresholds(16'hFFFF, 16'hFFFF);
    run_random(90);
    drain();

    set_thresholds(16'h4000, 16'hC000);
    run_random(90);
    drain();

    // no idling on either side for this stretch
    calm = 1'b1;
    set_thresholds(frac_t'($urandom_range(0, 65535)), frac_t'($urandom_range(0, 65535)));
    run_random(90);
    drain();
    calm = 1'b0;

    set_thresholds(16'h0000, 16'hFFFF);
    run_random(90);
    drain();

    set_thresholds(THR_RESET, 16'h0001);
    run_random(90);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("ising_heat_bath_site_update verification clean");
    end else begin
      $display("ising_heat_bath_site_update verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/ihb_pkg.sv
sv/ihb_ram.sv
sv/ising_heat_bath_site_update.sv
dv/ising_heat_bath_site_update_tb.sv
